// File: src/pwlbm_pkg.sv
`default_nettype none
package pwlbm_pkg;

  // Item actions
  localparam logic [1:0] ACT_WRITE    = 2'd0;
  localparam logic [1:0] ACT_D2T      = 2'd1;
  localparam logic [1:0] ACT_T2D      = 2'd2;
  localparam logic [1:0] ACT_VALIDATE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNAVAIL = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_SAT     = 2'd3;

  // Register indexes
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_CLAMP_MODE  = 1'b1;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MAG_W  = 32;
  localparam int PROD_W = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SEG,
    S_QSCAN,
    S_VSCAN,
    S_PREP,
    S_CALC,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_e;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
    logic [MAG_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] q;
  } md_rsp_t;

endpackage
`default_nettype wire

// File: src/pwlbm_ram.sv
`default_nettype none
module pwlbm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: src/pwlbm_muldiv.sv
`default_nettype none
// Bit-serial unsigned (a * b) / d: 32 shift-add steps, then 64 restoring divide steps.
module pwlbm_muldiv (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pwlbm_pkg::md_req_t req_i,
  output pwlbm_pkg::md_rsp_t      rsp_o
);

  localparam int MW = pwlbm_pkg::MAG_W;
  localparam int PW = pwlbm_pkg::PROD_W;
  localparam int CNT_W = $clog2(PW);

  pwlbm_pkg::md_state_e state_q, state_d;
  logic [PW-1:0]    acc_q;
  logic [MW-1:0]    ma_q, mb_q, d_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic [MW:0]      trial;
  logic             fits;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MW - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PW - 1);

  // restoring divide step
  assign trial = {rem_q, acc_q[PW-1]};
  assign fits  = trial >= {1'b0, d_q};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pwlbm_pkg::MD_IDLE: if (req_i.start) state_d = pwlbm_pkg::MD_MUL;
      pwlbm_pkg::MD_MUL:  if (cnt_q == MUL_LAST) state_d = pwlbm_pkg::MD_DIV;
      pwlbm_pkg::MD_DIV:  if (cnt_q == DIV_LAST) state_d = pwlbm_pkg::MD_DONE;
      pwlbm_pkg::MD_DONE: state_d = pwlbm_pkg::MD_IDLE;
      default:            state_d = pwlbm_pkg::MD_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.done = (state_q == pwlbm_pkg::MD_DONE);
    rsp_o.q    = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwlbm_pkg::MD_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      pwlbm_pkg::MD_IDLE: begin
        if (req_i.start) begin
          acc_q <= '0;
          ma_q  <= req_i.a;
          mb_q  <= req_i.b;
          d_q   <= req_i.d;
          cnt_q <= '0;
        end
      end
      pwlbm_pkg::MD_MUL: begin
        acc_q <= {acc_q[PW-2:0], 1'b0} + (mb_q[MW-1] ? PW'(ma_q) : '0);
        mb_q  <= {mb_q[MW-2:0], 1'b0};
        cnt_q <= (cnt_q == MUL_LAST) ? '0 : cnt_q + 1'b1;
        rem_q <= '0;
      end
      pwlbm_pkg::MD_DIV: begin
        rem_q <= fits ? MW'(trial - {1'b0, d_q}) : trial[MW-1:0];
        acc_q <= {acc_q[PW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: src/piecewise_linear_bidir_map.sv
`default_nettype none
// Depth/time mapping over a table of up to MAX_POINTS control points (signed Q24.8),
// held in one single-port-read RAM. A query reads the two end points, then either
// answers at once (clamp), reads one more end segment point, or scans the table
// one entry per cycle through the RAM read port until the first bracketing pair;
// the segment is then evaluated by a bit-serial multiply-divide unit. The result
// sits in an output register, so the next item is taken while it waits.
module piecewise_linear_bidir_map #(
  parameter int MAX_POINTS = pwlbm_pkg::MAX_POINTS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [5:0]  point_index_i,
  input  wire logic signed [31:0] point_depth_i,
  input  wire logic signed [31:0] point_time_i,
  input  wire logic signed [31:0] query_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic signed [31:0] mapped_value_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = (CW > 7) ? CW : 7;
  localparam logic signed [35:0] R_MAX = 36'sd2147483647;
  localparam logic signed [35:0] R_MIN = -36'sd2147483648;

  // config registers
  logic [6:0] point_count_q;
  logic       clamp_mode_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == pwlbm_pkg::REG_CLAMP_MODE) ? {31'b0, clamp_mode_q}
                                                           : {25'b0, point_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
      clamp_mode_q  <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == pwlbm_pkg::REG_POINT_COUNT) point_count_q <= pwdata[6:0];
      else                                        clamp_mode_q  <= pwdata[0];
    end
  end

  // state
  pwlbm_pkg::state_e state_q, state_d;
  logic [1:0]         act_q, act_d;
  logic signed [31:0] x_q, x_d;
  logic [63:0]        e0_q, e0_d, k_q, k_d, prev_q, prev_d;
  logic               klow_q, klow_d;
  logic [NW-1:0]      i_q, i_d;
  logic [31:0]        hito_q, hito_d;
  logic signed [31:0] x0_q, x0_d, x1_q, x1_d, y0_q, y0_d, y1_q, y1_d;
  logic               neg_q, neg_d, up_q, up_d, down_q, down_d;
  logic [1:0]         rst_q, rst_d;
  logic [31:0]        rval_q, rval_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         status_q;
  logic [31:0]        mapped_q;

  logic               accept, d2t, is_val, fin_go;
  logic [NW-1:0]      n, nm1;
  logic [63:0]        rdata;
  logic [AW-1:0]      raddr;
  logic               ram_we;
  logic               idx_ok;

  pwlbm_pkg::md_req_t md_req;
  pwlbm_pkg::md_rsp_t md_rsp;

  function automatic logic signed [31:0] fr_of(input logic [63:0] e, input logic dt);
    return dt ? e[63:32] : e[31:0];
  endfunction

  function automatic logic signed [31:0] to_of(input logic [63:0] e, input logic dt);
    return dt ? e[31:0] : e[63:32];
  endfunction

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != pwlbm_pkg::S_IDLE);
  assign d2t    = (act_q == pwlbm_pkg::ACT_D2T);
  assign is_val = (act_q == pwlbm_pkg::ACT_VALIDATE);
  assign n      = (32'(point_count_q) > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(point_count_q);
  assign nm1    = n - NW'(1);
  assign fin_go = !out_valid_q || !out_stall_i;
  assign idx_ok = 32'(point_index_i) < MAX_POINTS;
  assign ram_we = accept && (action_i == pwlbm_pkg::ACT_WRITE) && idx_ok;

  // end-point decode (entry n-1 on the read port, entry 0 in e0_q)
  logic               inc, below, above;
  logic [63:0]        lo_e, hi_e;
  logic [NW-1:0]      b_idx, a_idx;
  assign inc   = $signed(rdata[63:32]) > $signed(e0_q[63:32]);
  assign lo_e  = inc ? e0_q : rdata;
  assign hi_e  = inc ? rdata : e0_q;
  assign below = x_q <= fr_of(lo_e, d2t);
  assign above = x_q >= fr_of(hi_e, d2t);
  assign b_idx = inc ? NW'(1) : n - NW'(2);
  assign a_idx = inc ? n - NW'(2) : NW'(1);

  // scan compare: previous entry against the one just read
  logic signed [31:0] f0, f1;
  logic               hit, scan_last, up_n, down_n;
  assign f0 = fr_of(prev_q, d2t);
  assign f1 = fr_of(rdata, d2t);
  assign hit = ((x_q >= f0) && (x_q <= f1)) || ((x_q <= f0) && (x_q >= f1));
  assign scan_last = (i_q == nm1);
  assign up_n = up_q && ($signed(rdata[63:32]) > $signed(prev_q[63:32]))
                     && ($signed(rdata[31:0]) > $signed(prev_q[31:0]));
  assign down_n = down_q && ($signed(rdata[63:32]) < $signed(prev_q[63:32]))
                         && ($signed(rdata[31:0]) < $signed(prev_q[31:0]));

  // segment deltas
  logic signed [32:0] dx, dy, dd, ndx, ndy, ndd;
  assign dx  = {x_q[31], x_q} - {x0_q[31], x0_q};
  assign dy  = {y1_q[31], y1_q} - {y0_q[31], y0_q};
  assign dd  = {x1_q[31], x1_q} - {x0_q[31], x0_q};
  assign ndx = -dx;
  assign ndy = -dy;
  assign ndd = -dd;

  // result assembly from the quotient
  logic [63:0]        q;
  logic               qsat;
  logic signed [35:0] y0e, qe, r;
  assign q    = md_rsp.q;
  assign qsat = (|q[63:34]) || (q[33] && (|q[32:0]));
  assign y0e  = 36'(y0_q);
  assign qe   = $signed({2'b0, q[33:0]});
  assign r    = neg_q ? y0e - qe : y0e + qe;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pwlbm_pkg::S_IDLE: begin
        if (accept) begin
          if (action_i == pwlbm_pkg::ACT_WRITE) state_d = pwlbm_pkg::S_FIN;
          else if (n < NW'(2))                  state_d = pwlbm_pkg::S_FIN;
          else                                  state_d = pwlbm_pkg::S_FIRST;
        end
      end
      pwlbm_pkg::S_FIRST: state_d = is_val ? pwlbm_pkg::S_VSCAN : pwlbm_pkg::S_LAST;
      pwlbm_pkg::S_LAST: begin
        if (below || above) state_d = clamp_mode_q ? pwlbm_pkg::S_FIN : pwlbm_pkg::S_SEG;
        else                state_d = pwlbm_pkg::S_QSCAN;
      end
      pwlbm_pkg::S_SEG: state_d = pwlbm_pkg::S_PREP;
      pwlbm_pkg::S_QSCAN: begin
        if (hit)            state_d = pwlbm_pkg::S_PREP;
        else if (scan_last) state_d = pwlbm_pkg::S_FIN;
      end
      pwlbm_pkg::S_VSCAN: if (scan_last) state_d = pwlbm_pkg::S_FIN;
      pwlbm_pkg::S_PREP:  state_d = (dd == '0) ? pwlbm_pkg::S_FIN : pwlbm_pkg::S_CALC;
      pwlbm_pkg::S_CALC:  if (md_rsp.done) state_d = pwlbm_pkg::S_FIN;
      pwlbm_pkg::S_FIN:   if (fin_go) state_d = pwlbm_pkg::S_IDLE;
      default:            state_d = pwlbm_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_d = act_q;   x_d = x_q;     e0_d = e0_q;   k_d = k_q;     klow_d = klow_q;
    prev_d = prev_q; i_d = i_q;     hito_d = hito_q;
    x0_d = x0_q;     x1_d = x1_q;   y0_d = y0_q;   y1_d = y1_q;
    neg_d = neg_q;   up_d = up_q;   down_d = down_q;
    rst_d = rst_q;   rval_d = rval_q;
    raddr = '0;
    md_req = '0;
    case (state_q)
      pwlbm_pkg::S_IDLE: begin
        if (accept) begin
          act_d  = action_i;
          x_d    = query_value_i;
          rval_d = '0;
          rst_d  = pwlbm_pkg::ST_OK;
          if (action_i == pwlbm_pkg::ACT_VALIDATE) begin
            if (n == NW'(1)) rst_d = pwlbm_pkg::ST_INVALID;
          end else if (action_i != pwlbm_pkg::ACT_WRITE) begin
            if (n < NW'(2)) rst_d = pwlbm_pkg::ST_UNAVAIL;
          end
        end
      end
      pwlbm_pkg::S_FIRST: begin
        e0_d   = rdata;
        prev_d = rdata;
        i_d    = NW'(1);
        up_d   = 1'b1;
        down_d = 1'b1;
        raddr  = is_val ? AW'(1) : nm1[AW-1:0];
      end
      pwlbm_pkg::S_LAST: begin
        hito_d = to_of(hi_e, d2t);
        prev_d = e0_q;
        i_d    = NW'(1);
        raddr  = AW'(1);
        if (below) begin
          k_d    = lo_e;
          klow_d = 1'b1;
          rval_d = to_of(lo_e, d2t);
          raddr  = b_idx[AW-1:0];
        end else if (above) begin
          k_d    = hi_e;
          klow_d = 1'b0;
          rval_d = to_of(hi_e, d2t);
          raddr  = a_idx[AW-1:0];
        end
      end
      pwlbm_pkg::S_SEG: begin
        if (klow_q) begin
          x0_d = fr_of(k_q, d2t);   y0_d = to_of(k_q, d2t);
          x1_d = fr_of(rdata, d2t); y1_d = to_of(rdata, d2t);
        end else begin
          x0_d = fr_of(rdata, d2t); y0_d = to_of(rdata, d2t);
          x1_d = fr_of(k_q, d2t);   y1_d = to_of(k_q, d2t);
        end
      end
      pwlbm_pkg::S_QSCAN: begin
        raddr = AW'(i_q + NW'(1));
        if (hit) begin
          x0_d = f0; y0_d = to_of(prev_q, d2t);
          x1_d = f1; y1_d = to_of(rdata, d2t);
        end else begin
          rval_d = hito_q;
          prev_d = rdata;
          i_d    = i_q + NW'(1);
        end
      end
      pwlbm_pkg::S_VSCAN: begin
        raddr  = AW'(i_q + NW'(1));
        up_d   = up_n;
        down_d = down_n;
        prev_d = rdata;
        i_d    = i_q + NW'(1);
        rst_d  = (up_n || down_n) ? pwlbm_pkg::ST_OK : pwlbm_pkg::ST_INVALID;
      end
      pwlbm_pkg::S_PREP: begin
        neg_d = (dx[32] != dy[32]) != dd[32];
        md_req.start = (dd != '0);
        md_req.a = dx[32] ? ndx[31:0] : dx[31:0];
        md_req.b = dy[32] ? ndy[31:0] : dy[31:0];
        md_req.d = dd[32] ? ndd[31:0] : dd[31:0];
        if (dd == '0) begin
          rst_d  = pwlbm_pkg::ST_INVALID;
          rval_d = '0;
        end
      end
      pwlbm_pkg::S_CALC: begin
        if (md_rsp.done) begin
          if (qsat) begin
            rst_d  = pwlbm_pkg::ST_SAT;
            rval_d = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
          end else if (r > R_MAX) begin
            rst_d  = pwlbm_pkg::ST_SAT;
            rval_d = 32'h7FFF_FFFF;
          end else if (r < R_MIN) begin
            rst_d  = pwlbm_pkg::ST_SAT;
            rval_d = 32'h8000_0000;
          end else begin
            rst_d  = pwlbm_pkg::ST_OK;
            rval_d = r[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  assign out_valid_d = (state_q == pwlbm_pkg::S_FIN && fin_go) ||
                       (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pwlbm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;   x_q <= x_d;     e0_q <= e0_d;   k_q <= k_d;     klow_q <= klow_d;
    prev_q <= prev_d; i_q <= i_d;     hito_q <= hito_d;
    x0_q <= x0_d;     x1_q <= x1_d;   y0_q <= y0_d;   y1_q <= y1_d;
    neg_q <= neg_d;   up_q <= up_d;   down_q <= down_d;
    rst_q <= rst_d;   rval_q <= rval_d;
    if (state_q == pwlbm_pkg::S_FIN && fin_go) begin
      status_q <= rst_q;
      mapped_q <= rval_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign mapped_value_o = mapped_q;

  pwlbm_ram #(
    .WIDTH(64),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(point_index_i)),
    .wdata_i ({point_depth_i, point_time_i}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pwlbm_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o) else $error("accepted item did not make the block busy");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == pwlbm_pkg::S_FIN))
    else $error("result appeared outside the finish state");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == pwlbm_pkg::ST_UNAVAIL || status_o == pwlbm_pkg::ST_INVALID)
    |-> mapped_value_o == '0) else $error("nonzero value with error status");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> state_q == pwlbm_pkg::S_CALC)
    else $error("multiply-divide finished while not awaited");
`endif

endmodule
`default_nettype wire

// File: bench/tb_piecewise_linear_bidir_map.sv
`default_nettype none
module tb_piecewise_linear_bidir_map;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 64;
  localparam logic [2:0] ADDR_POINT_COUNT = 3'(4 * pwlbm_pkg::REG_POINT_COUNT);
  localparam logic [2:0] ADDR_CLAMP_MODE  = 3'(4 * pwlbm_pkg::REG_CLAMP_MODE);

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  logic [1:0] action;
  logic [5:0] point_index;
  logic signed [31:0] point_depth;
  logic signed [31:0] point_time;
  logic signed [31:0] query_value;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic signed [31:0] mapped_value;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  piecewise_linear_bidir_map DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .point_index_i(point_index),
    .point_depth_i(point_depth), .point_time_i(point_time),
    .query_value_i(query_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .mapped_value_o(mapped_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the block's table and registers
  int depth_tab[NPTS];
  int time_tab[NPTS];
  int unsigned pt_count;
  bit clamp_on;

  logic [1:0] exp_status_q[$];
  logic [31:0] exp_value_q[$];
  int errors;
  bit idling;
  int items_sent;
  int out_stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("piecewise_linear_bidir_map verification failed");
    $finish;
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  // Evaluate one segment (x0,y0)-(x1,y1) at x
  function automatic void seg_eval(longint x, longint x0, longint x1, longint y0,
                                   longint y1, output logic [1:0] st, output longint r);
    longint dx, dy, dd;
    longint unsigned q;
    bit neg;
    dx = x - x0;
    dy = y1 - y0;
    dd = x1 - x0;
    if (dd == 0) begin
      st = pwlbm_pkg::ST_INVALID;
      r = 0;
      return;
    end
    neg = ((dx < 0) != (dy < 0)) != (dd < 0);
    q = (mag64(dx) * mag64(dy)) / mag64(dd);
    if (q == 0) neg = 1'b0;
    if (q > 64'h2_0000_0000) begin
      st = pwlbm_pkg::ST_SAT;
      r = neg ? -64'sd2147483648 : 64'sd2147483647;
      return;
    end
    r = neg ? y0 - longint'(q) : y0 + longint'(q);
    st = pwlbm_pkg::ST_OK;
    if (r > 64'sd2147483647) begin
      st = pwlbm_pkg::ST_SAT;
      r = 64'sd2147483647;
    end else if (r < -64'sd2147483648) begin
      st = pwlbm_pkg::ST_SAT;
      r = -64'sd2147483648;
    end
  endfunction

  function automatic longint src_pt(int i, bit d2t);
    return d2t ? depth_tab[i] : time_tab[i];
  endfunction

  function automatic longint dst_pt(int i, bit d2t);
    return d2t ? time_tab[i] : depth_tab[i];
  endfunction

  function automatic void map_coord(longint x, bit d2t, output logic [1:0] st,
                                    output longint r);
    int n, lo, hi, a, b;
    bit inc;
    longint f0, f1;
    n = pt_count > NPTS ? NPTS : pt_count;
    if (n < 2) begin
      st = pwlbm_pkg::ST_UNAVAIL;
      r = 0;
      return;
    end
    inc = depth_tab[n-1] > depth_tab[0];
    lo = inc ? 0 : n - 1;
    hi = inc ? n - 1 : 0;
    if (x <= src_pt(lo, d2t)) begin
      b = inc ? 1 : n - 2;
      if (clamp_on) begin
        st = pwlbm_pkg::ST_OK;
        r = dst_pt(lo, d2t);
      end else begin
        seg_eval(x, src_pt(lo, d2t), src_pt(b, d2t), dst_pt(lo, d2t), dst_pt(b, d2t), st, r);
      end
      return;
    end
    if (x >= src_pt(hi, d2t)) begin
      a = inc ? n - 2 : 1;
      if (clamp_on) begin
        st = pwlbm_pkg::ST_OK;
        r = dst_pt(hi, d2t);
      end else begin
        seg_eval(x, src_pt(a, d2t), src_pt(hi, d2t), dst_pt(a, d2t), dst_pt(hi, d2t), st, r);
      end
      return;
    end
    for (int i = 1; i < n; i++) begin
      f0 = src_pt(i-1, d2t);
      f1 = src_pt(i, d2t);
      if ((x >= f0 && x <= f1) || (x <= f0 && x >= f1)) begin
        seg_eval(x, f0, f1, dst_pt(i-1, d2t), dst_pt(i, d2t), st, r);
        return;
      end
    end
    st = pwlbm_pkg::ST_OK;
    r = dst_pt(hi, d2t);
  endfunction

  function automatic logic [1:0] check_monotonic();
    int n;
    bit up, down;
    n = pt_count > NPTS ? NPTS : pt_count;
    up = 1'b1;
    down = 1'b1;
    if (n == 0) return pwlbm_pkg::ST_OK;
    if (n < 2) return pwlbm_pkg::ST_INVALID;
    for (int i = 1; i < n; i++) begin
      if (depth_tab[i] <= depth_tab[i-1] || time_tab[i] <= time_tab[i-1]) up = 1'b0;
      if (depth_tab[i] >= depth_tab[i-1] || time_tab[i] >= time_tab[i-1]) down = 1'b0;
    end
    return (up || down) ? pwlbm_pkg::ST_OK : pwlbm_pkg::ST_INVALID;
  endfunction

  // Apply one accepted item to the shadow and queue its expected result
  function automatic void predict_item(logic [1:0] act, logic [5:0] idx, int d, int t,
                                       int qv);
    logic [1:0] st;
    longint r;
    st = pwlbm_pkg::ST_OK;
    r = 0;
    case (act)
      pwlbm_pkg::ACT_WRITE: begin
        depth_tab[idx] = d;
        time_tab[idx] = t;
      end
      pwlbm_pkg::ACT_VALIDATE: st = check_monotonic();
      default: begin
        map_coord(longint'(qv), act == pwlbm_pkg::ACT_D2T, st, r);
        if (st == pwlbm_pkg::ST_UNAVAIL || st == pwlbm_pkg::ST_INVALID) r = 0;
      end
    endcase
    exp_status_q.push_back(st);
    exp_value_q.push_back(r[31:0]);
  endfunction

  // One input transfer; valid stays high afterward
  task automatic send_item(logic [1:0] act, logic [5:0] idx, logic [31:0] d,
                           logic [31:0] t, logic [31:0] qv);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= act;
    point_index <= idx;
    point_depth <= d;
    point_time <= t;
    query_value <= qv;
    do @(posedge clk_i); while (in_stall);
    predict_item(act, idx, d, t, qv);
    items_sent++;
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (exp_status_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_POINT_COUNT) pt_count = data & 32'h7f;
    else clamp_on = data[0];
  endtask

  task automatic set_config(int unsigned cnt, bit clamp);
    drain();
    reg_write(ADDR_POINT_COUNT, cnt);
    reg_write(ADDR_CLAMP_MODE, 32'(clamp));
  endtask

  task automatic query_both(logic [31:0] v);
    send_item(pwlbm_pkg::ACT_D2T, 6'($urandom), $urandom, $urandom, v);
    send_item(pwlbm_pkg::ACT_T2D, 6'($urandom), $urandom, $urandom, v);
  endtask

  // Empty and one-point tables: nothing is read from the table
  task automatic test_short_table();
    send_item(pwlbm_pkg::ACT_VALIDATE, 6'h3f, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    query_both(32'h80000000);
    query_both(32'h7fffffff);
    set_config(1, 1'b1);
    send_item(pwlbm_pkg::ACT_VALIDATE, 6'd0, 32'd0, 32'd0, 32'd0);
    query_both(32'h0);
  endtask

  // Fill every slot with a rising table spanning the full range
  task automatic test_full_table();
    logic [31:0] d, t;
    for (int i = 0; i < NPTS; i++) begin
      d = (i == 0) ? 32'h80000000 : (i == NPTS - 1) ? 32'h7fffffff : (i - 32) * 32'h01000000;
      t = (i == 0) ? 32'h80000000 : (i == NPTS - 1) ? 32'h7fffffff : (i - 32) * 32'h00400000;
      send_item(pwlbm_pkg::ACT_WRITE, 6'(i), d, t, $urandom);
    end
    set_config(NPTS, 1'b0);
    send_item(pwlbm_pkg::ACT_VALIDATE, 6'd0, 32'd0, 32'd0, 32'd0);
    query_both(32'h80000000);
    query_both(32'h7fffffff);
    query_both(32'h00123456);
    set_config(127, 1'b1);
    query_both(32'h80000000);
    query_both(32'h7fffffff);
    // Extrapolation far beyond a short steep segment saturates
    set_config(2, 1'b0);
    query_both(32'h7fffffff);
    // Repeated depth makes the end segment zero length
    send_item(pwlbm_pkg::ACT_WRITE, 6'd1, 32'h80000000, 32'h00000100, 32'd0);
    query_both(32'h80000000);
    send_item(pwlbm_pkg::ACT_VALIDATE, 6'd0, 32'd0, 32'd0, 32'd0);
  endtask

  function automatic int rand_scaled();
    int w;
    w = $urandom_range(4, 32);
    return int'($urandom) >>> (32 - w);
  endfunction

  task automatic sort_vals(ref int v[NPTS], input int n, input bit down);
    int tmp;
    for (int i = 1; i < n; i++)
      for (int j = i; j > 0 && (down ? v[j] > v[j-1] : v[j] < v[j-1]); j--) begin
        tmp = v[j];
        v[j] = v[j-1];
        v[j-1] = tmp;
      end
  endtask

  // Random tables, mostly monotonic, each followed by a burst of queries
  task automatic test_random_tables();
    int dv[NPTS];
    int tv[NPTS];
    int n, kind, nq;
    bit down;
    logic [31:0] qv;
    while (items_sent < 640) begin
      if (items_sent > 560) idling = 1'b0;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(2, NPTS) : $urandom_range(2, 8);
      kind = $urandom_range(0, 9);
      down = $urandom_range(0, 1);
      for (int i = 0; i < n; i++) begin
        dv[i] = rand_scaled();
        tv[i] = rand_scaled();
      end
      if (kind < 8) begin
        sort_vals(dv, n, down);
        sort_vals(tv, n, (kind == 7) ? !down : down);
      end
      for (int i = 0; i < n; i++)
        send_item(pwlbm_pkg::ACT_WRITE, 6'(i), dv[i], tv[i], $urandom);
      if ($urandom_range(0, 3) == 0) begin
        kind = $urandom_range(0, NPTS - 1);
        if (kind >= n)
          send_item(pwlbm_pkg::ACT_WRITE, 6'(kind), $urandom, $urandom, $urandom);
      end
      set_config((n == NPTS && $urandom_range(0, 1)) ? $urandom_range(NPTS, 127) : n,
                 $urandom_range(0, 3) == 0);
      send_item(pwlbm_pkg::ACT_VALIDATE, 6'($urandom), $urandom, $urandom, $urandom);
      nq = $urandom_range(6, 16);
      for (int k = 0; k < nq; k++) begin
        kind = $urandom_range(0, n - 1);
        case ($urandom_range(0, 4))
          0: qv = (kind % 2) ? dv[kind] : tv[kind];
          1: qv = ((kind % 2) ? dv[kind] : tv[kind]) + $signed($urandom_range(0, 64)) - 32;
          2: qv = $urandom;
          3: qv = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
          default: qv = rand_scaled();
        endcase
        send_item($urandom_range(0, 1) ? pwlbm_pkg::ACT_D2T : pwlbm_pkg::ACT_T2D,
                  6'($urandom), $urandom, $urandom, qv);
      end
    end
  endtask

  // Result stall bursts and result checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      out_stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (exp_status_q.size() == 0) begin
          $display("%0t: unexpected result status=%0d value=%h", $time, status,
                   mapped_value);
          errors++;
        end else begin
          if (status !== exp_status_q[0]) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_status_q[0], status);
            errors++;
          end
          if (mapped_value !== exp_value_q[0]) begin
            $display("%0t: mapped_value expected %h actual %h", $time, exp_value_q[0],
                     mapped_value);
            errors++;
          end
          void'(exp_status_q.pop_front());
          void'(exp_value_q.pop_front());
        end
      end
      if (out_stall_left > 0) begin
        out_stall_left <= out_stall_left - 1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        out_stall_left <= $urandom_range(1, 15);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    idling = 1'b1;
    pt_count = 0;
    clamp_on = 1'b0;
    foreach (depth_tab[i]) begin
      depth_tab[i] = 0;
      time_tab[i] = 0;
    end
    rst_ni = 1'b0;
    in_valid = 1'b0;
    action = pwlbm_pkg::ACT_WRITE;
    point_index = '0;
    point_depth = '0;
    point_time = '0;
    query_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_table();
    test_full_table();
    test_random_tables();
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0 && exp_status_q.size() == 0) begin
      $display("piecewise_linear_bidir_map verification clean");
    end else begin
      $display("piecewise_linear_bidir_map verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
